/* hdl/rmts_pkg.sv */
package rmts_pkg;

    // Number of task slots held in the register file.
    localparam int SLOT_COUNT = 4;

    localparam int TASK_W  = 2;
    localparam int SEL_W   = 3;
    localparam int VAL_W   = 16;
    localparam int TIME_W  = 32;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    typedef logic [TASK_W-1:0] task_idx_t;
    typedef logic [SEL_W-1:0]  sel_t;
    typedef logic [VAL_W-1:0]  val_t;
    typedef logic [TIME_W-1:0] tick_time_t;

    // Selection code for a tick on which no task runs.
    localparam sel_t SEL_IDLE = 3'd4;

    // Register groups: the upper address bit picks periods or bursts.
    localparam logic CFG_GRP_PERIOD = 1'b0;
    localparam logic CFG_GRP_BURST  = 1'b1;

endpackage

/* hdl/rmts_if.sv */
interface rmts_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface rmts_result_if;
    logic                   valid;
    logic                   ready;
    rmts_pkg::task_idx_t    running_task;
    logic                   cpu_idle;
    logic                   switched;
    rmts_pkg::tick_time_t   tick_time;

    modport source (output valid, output running_task, output cpu_idle,
                    output switched, output tick_time, input ready);
    modport sink   (input valid, input running_task, input cpu_idle,
                    input switched, input tick_time, output ready);
endinterface

/* hdl/rate_monotonic_tick_scheduler.sv */
// A tick accepted at a clock edge has its result on the output register from the
// next cycle on.
// Throughput: one tick per cycle while results are taken; the release countdowns, the
// four-way period compare and budget decrement sit between state and output registers.
// Reset: rst_n clears configuration, budgets, countdowns, time and the output
// valid flag at once; there is no clearing pass.
module rate_monotonic_tick_scheduler #(
    parameter int NUM_TASKS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rmts_pkg::ADDR_W-1:0]   paddr,
    input  logic [rmts_pkg::DATA_W-1:0]   pwdata,
    output logic [rmts_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    rmts_tick_if.sink                     tick_in,
    rmts_result_if.source                 result_out
);

    rmts_pkg::val_t       period_reg [rmts_pkg::SLOT_COUNT];
    rmts_pkg::val_t       burst_reg  [rmts_pkg::SLOT_COUNT];
    rmts_pkg::val_t       budget_reg [rmts_pkg::SLOT_COUNT];
    rmts_pkg::val_t       budget_next[rmts_pkg::SLOT_COUNT];
    rmts_pkg::val_t       cd_reg     [rmts_pkg::SLOT_COUNT];
    rmts_pkg::val_t       cd_next    [rmts_pkg::SLOT_COUNT];
    rmts_pkg::sel_t       last_reg;
    rmts_pkg::sel_t       sel_next;
    rmts_pkg::tick_time_t time_reg;
    rmts_pkg::tick_time_t time_cur;

    logic                 out_valid_reg;
    rmts_pkg::task_idx_t  out_task_reg;
    logic                 out_idle_reg;
    logic                 out_switched_reg;
    rmts_pkg::tick_time_t out_time_reg;

    logic                 found;
    rmts_pkg::task_idx_t  chosen;
    logic                 out_switched_comb;
    logic                 cfg_wr;
    logic                 tick_fire;
    logic [1:0]           cfg_slot;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign cfg_slot  = paddr[3:2];
    assign tick_in.ready = !out_valid_reg || result_out.ready;
    assign tick_fire = tick_in.valid && tick_in.ready;

    always_comb
    begin
        if (paddr[4] == rmts_pkg::CFG_GRP_PERIOD)
        begin
            prdata = {16'd0, period_reg[cfg_slot]};
        end
        else
        begin
            prdata = {16'd0, burst_reg[cfg_slot]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < rmts_pkg::SLOT_COUNT; k++)
            begin
                period_reg[k] <= '0;
                burst_reg[k]  <= '0;
            end
        end
        else if (cfg_wr)
        begin
            if (paddr[4] == rmts_pkg::CFG_GRP_PERIOD)
            begin
                period_reg[cfg_slot] <= pwdata[rmts_pkg::VAL_W-1:0];
            end
            else
            begin
                burst_reg[cfg_slot] <= pwdata[rmts_pkg::VAL_W-1:0];
            end
        end
    end

    // One tick: restart, releases, priority pick, budget decrement.
    always_comb
    begin
        rmts_pkg::val_t       bud [rmts_pkg::SLOT_COUNT];
        rmts_pkg::val_t       best;
        rmts_pkg::sel_t       last_cur;

        last_cur = last_reg;
        time_cur = time_reg;
        for (int k = 0; k < rmts_pkg::SLOT_COUNT; k++)
        begin
            bud[k]     = budget_reg[k];
            cd_next[k] = cd_reg[k];
        end
        if (tick_in.restart)
        begin
            last_cur = rmts_pkg::SEL_IDLE;
            time_cur = '0;
            for (int k = 0; k < rmts_pkg::SLOT_COUNT; k++)
            begin
                bud[k]     = '0;
                cd_next[k] = '0;
            end
        end

        for (int k = 0; k < rmts_pkg::SLOT_COUNT; k++)
        begin
            if (k >= NUM_TASKS || period_reg[k] == '0)
            begin
                bud[k]     = '0;
                cd_next[k] = '0;
            end
            else if (cd_next[k] == '0)
            begin
                bud[k]     = burst_reg[k];
                cd_next[k] = period_reg[k] - 16'd1;
            end
            else
            begin
                cd_next[k] = cd_next[k] - 16'd1;
            end
        end

        // Shortest period wins; strict compare keeps the lowest index on a tie.
        found  = 1'b0;
        chosen = '0;
        best   = '0;
        for (int k = 0; k < rmts_pkg::SLOT_COUNT; k++)
        begin
            if (k < NUM_TASKS && period_reg[k] != '0 && bud[k] != '0 &&
                (!found || period_reg[k] < best))
            begin
                found  = 1'b1;
                chosen = rmts_pkg::TASK_W'(k);
                best   = period_reg[k];
            end
        end

        sel_next = found ? {1'b0, chosen} : rmts_pkg::SEL_IDLE;
        for (int k = 0; k < rmts_pkg::SLOT_COUNT; k++)
        begin
            budget_next[k] = bud[k];
        end
        if (found)
        begin
            budget_next[chosen] = bud[chosen] - 16'd1;
        end
        out_switched_comb = (sel_next != last_cur);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < rmts_pkg::SLOT_COUNT; k++)
            begin
                budget_reg[k] <= '0;
                cd_reg[k]     <= '0;
            end
            last_reg      <= rmts_pkg::SEL_IDLE;
            time_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tick_fire)
            begin
                for (int k = 0; k < rmts_pkg::SLOT_COUNT; k++)
                begin
                    budget_reg[k] <= budget_next[k];
                    cd_reg[k]     <= cd_next[k];
                end
                last_reg      <= sel_next;
                time_reg      <= time_cur + 32'd1;
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            out_task_reg     <= found ? chosen : '0;
            out_idle_reg     <= !found;
            out_switched_reg <= out_switched_comb;
            out_time_reg     <= time_cur;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.running_task = out_task_reg;
    assign result_out.cpu_idle     = out_idle_reg;
    assign result_out.switched     = out_switched_reg;
    assign result_out.tick_time    = out_time_reg;

endmodule

/* hdl/rmts_checker.sv */
module rmts_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        in_restart,
    input logic                        out_valid,
    input logic                        out_ready,
    input rmts_pkg::task_idx_t         out_task,
    input logic                        out_idle,
    input logic                        out_switched,
    input rmts_pkg::tick_time_t        out_time
);

    // A result that is not taken holds its beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_time) && $stable(out_task)
            && $stable(out_idle) && $stable(out_switched))
        else $error("stalled result beat changed");

    // A restart tick reports time zero on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_restart |=> out_valid && out_time == '0)
        else $error("restart tick did not report time zero");

    // Consecutive ticks without a restart advance time by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_restart && out_valid
            |=> out_time == $past(out_time) + 32'd1)
        else $error("tick time did not advance by one");

    // An idle tick reports task zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_idle |-> out_task == '0)
        else $error("idle tick reports a task");

endmodule

bind rate_monotonic_tick_scheduler rmts_checker u_rmts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (tick_in.valid),
    .in_ready     (tick_in.ready),
    .in_restart   (tick_in.restart),
    .out_valid    (result_out.valid),
    .out_ready    (result_out.ready),
    .out_task     (result_out.running_task),
    .out_idle     (result_out.cpu_idle),
    .out_switched (result_out.switched),
    .out_time     (result_out.tick_time)
);
